// ===== rtl/mflg_pkg.sv =====
// ----------------------------------------------------------------------------
// mflg_pkg
// Shared types and constants for the level-graph max flow block.
// ----------------------------------------------------------------------------
`default_nettype none

package mflg_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int CAP_BITS_DEF  = 24;

  localparam int OPCODE_W   = 1;
  localparam int NODE_W     = 6;
  localparam int CAPACITY_W = 24;
  localparam int FLOW_W     = 30;
  localparam int NCOUNT_W   = 7;

  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
  localparam int                  PUSH_LIMIT       = 100000000;
  localparam int                  PUSH_LIMIT_W     = 27;

  localparam logic [OPCODE_W-1:0] OP_EDGE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_RUN  = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE,
    S_LVL_CLR,
    S_BFS_INIT,
    S_BFS_HEAD,
    S_BFS_HEADW,
    S_BFS_LVLW,
    S_BFS_ISSUE,
    S_BFS_EVAL,
    S_AUG_INIT,
    S_DFS_TOP,
    S_DFS_TRYW,
    S_DFS_ISSUE,
    S_DFS_EVAL,
    S_DFS_PUSH2,
    S_DFS_POP,
    S_DFS_POPW,
    S_NK_RD,
    S_NK_RDW,
    S_NK_CMP,
    S_UP_RD,
    S_UP_RDW,
    S_UP_SUB,
    S_UP_ADD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/mflg_if.sv =====
// ----------------------------------------------------------------------------
// mflg interfaces
// Valid/ready channels for input items, results and the config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mflg_in_if;
  logic                              valid;
  logic                              ready;
  logic [mflg_pkg::OPCODE_W-1:0]     opcode;
  logic [mflg_pkg::NODE_W-1:0]       from_node;
  logic [mflg_pkg::NODE_W-1:0]       to_node;
  logic [mflg_pkg::CAPACITY_W-1:0]   capacity;
  modport source (output valid, opcode, from_node, to_node, capacity, input ready);
  modport sink   (input valid, opcode, from_node, to_node, capacity, output ready);
endinterface

interface mflg_out_if;
  logic                          valid;
  logic                          ready;
  logic [mflg_pkg::FLOW_W-1:0]   max_flow;
  modport source (output valid, max_flow, input ready);
  modport sink   (input valid, max_flow, output ready);
endinterface

interface mflg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mflg_pkg::NCOUNT_W-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/max_flow_level_graph.sv =====
// ----------------------------------------------------------------------------
// max_flow_level_graph
// Dinic style max flow over a residual capacity matrix held in RAM.
// ----------------------------------------------------------------------------
// Edge beats do one read-modify-write of the matrix RAM; edges naming a node
// outside node_count write nothing. A run beat walks the graph through one
// sequencer and one read port per RAM: each breadth-first phase scans the
// matrix one entry at a time, each path search tries one entry at a time,
// and each push makes a bottleneck pass and then an update pass over the
// path edges. After the result is loaded, and after reset, a clearing pass
// writes every matrix entry (4096 by default); a run starts with a level
// clear of all MAX_NODES entries. Config writes are taken at any time.
`default_nettype none

module max_flow_level_graph #(
  parameter int MAX_NODES = mflg_pkg::MAX_NODES_DEF,
  parameter int CAP_BITS  = mflg_pkg::CAP_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  mflg_in_if.sink   edges,
  mflg_out_if.source result,
  mflg_cfg_if.sink  cfg
);
  import mflg_pkg::*;

  localparam int NB   = $clog2(MAX_NODES);
  localparam int CB   = CAP_BITS + 1;
  localparam int LB   = $clog2(MAX_NODES + 1);
  localparam int TW   = $clog2(MAX_NODES + 1);
  localparam int DW   = $clog2(MAX_NODES + 2);
  localparam int SAW  = $clog2(MAX_NODES + 1);
  localparam int CMPW = (NB + 1 > 7) ? NB + 1 : 7;
  localparam int NW   = (CB > PUSH_LIMIT_W) ? CB : PUSH_LIMIT_W;
  localparam int SW   = ((CAP_BITS > CAPACITY_W) ? CAP_BITS : CAPACITY_W) + 2;
  localparam logic [SW-1:0] CAP_MAX = {{(SW-CAP_BITS){1'b0}}, {CAP_BITS{1'b1}}};

  state_t state, state_next;

  logic [2*NB-1:0]     clr;
  logic [TW-1:0]       head, tail;
  logic                reached;
  logic [MAX_NODES-1:0] visited, dead;
  logic [NB-1:0]       u, a, b;
  logic [LB-1:0]       lvl_u;
  logic [NB:0]         v;
  logic [DW-1:0]       depth, idx;
  logic [NW-1:0]       neck;
  logic [FLOW_W-1:0]   flow;
  logic [NCOUNT_W-1:0] node_count;
  logic [2*NB-1:0]     e_addr;
  logic [CAPACITY_W-1:0] e_cap;
  logic                out_valid;
  logic [FLOW_W-1:0]   max_flow;

  logic            cap_we;
  logic [2*NB-1:0] cap_waddr, cap_raddr;
  logic [CB-1:0]   cap_wdata, cap_rdata;
  logic            lvl_we;
  logic [NB-1:0]   lvl_waddr, lvl_raddr;
  logic [LB-1:0]   lvl_wdata, lvl_rdata;
  logic            q_we;
  logic [NB-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;
  logic            st_we;
  logic [SAW-1:0]  st_waddr, st_raddr;
  logic [NB-1:0]   st_wdata, st_rdata;
  logic            nt_we;
  logic [NB-1:0]   nt_waddr, nt_raddr;
  logic [NB:0]     nt_wdata, nt_rdata;

  mflg_ram #(.W(CB), .D(2**(2*NB))) u_cap (
    .clk, .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
    .raddr(cap_raddr), .rdata(cap_rdata));
  mflg_ram #(.W(LB), .D(MAX_NODES)) u_lvl (
    .clk, .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata));
  mflg_ram #(.W(NB), .D(MAX_NODES)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata));
  mflg_ram #(.W(NB), .D(MAX_NODES + 1)) u_stack (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata));
  mflg_ram #(.W(NB + 1), .D(MAX_NODES)) u_next (
    .clk, .we(nt_we), .waddr(nt_waddr), .wdata(nt_wdata),
    .raddr(nt_raddr), .rdata(nt_rdata));

  logic [CMPW-1:0] n;
  logic [NB-1:0]   sink;
  logic            in_acc, from_ok, v_lt_n, dfs_ok, depth_ok;
  logic [LB:0]     lvl_inc;
  logic [SW-1:0]   e_sum, e_sat;
  logic [NB-1:0]   v_idx;

  always_comb begin
    if (CMPW'(node_count) < CMPW'(2)) begin
      n = CMPW'(2);
    end else if (CMPW'(node_count) > CMPW'(MAX_NODES)) begin
      n = CMPW'(MAX_NODES);
    end else begin
      n = CMPW'(node_count);
    end
  end

  assign sink     = NB'(n - CMPW'(1));
  assign in_acc   = edges.valid && edges.ready;
  assign from_ok  = (CMPW'(edges.from_node) < n) && (CMPW'(edges.to_node) < n);
  assign v_idx    = NB'(v);
  assign v_lt_n   = CMPW'(v) < n;
  assign lvl_inc  = (LB + 1)'(lvl_u) + (LB + 1)'(1);
  assign dfs_ok   = (cap_rdata != '0) &&
                    (((LB + 1)'(lvl_rdata) == lvl_inc) || (v_idx == sink)) && !dead[v_idx];
  assign depth_ok = depth <= DW'(MAX_NODES);
  assign e_sum    = SW'(cap_rdata) + SW'(e_cap);
  assign e_sat    = (e_sum > CAP_MAX) ? CAP_MAX : e_sum;

  assign edges.ready     = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign result.valid    = out_valid;
  assign result.max_flow = max_flow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cap_we = 1'b0; cap_waddr = '0; cap_wdata = '0; cap_raddr = '0;
    lvl_we = 1'b0; lvl_waddr = '0; lvl_wdata = '0; lvl_raddr = '0;
    q_we   = 1'b0; q_waddr   = '0; q_wdata   = '0; q_raddr   = '0;
    st_we  = 1'b0; st_waddr  = '0; st_wdata  = '0; st_raddr  = '0;
    nt_we  = 1'b0; nt_waddr  = '0; nt_wdata  = '0; nt_raddr  = '0;
    case (state)
      S_CLEAR: begin
        cap_we    = 1'b1;
        cap_waddr = clr;
        if (clr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        cap_raddr = {NB'(edges.from_node), NB'(edges.to_node)};
        if (in_acc) begin
          if (edges.opcode == OP_RUN) begin
            state_next = S_LVL_CLR;
          end else if (from_ok) begin
            state_next = S_EDGE;
          end
        end
      end
      S_EDGE: begin
        cap_we     = SW'(cap_rdata) <= CAP_MAX;
        cap_waddr  = e_addr;
        cap_wdata  = CB'(e_sat);
        state_next = S_IDLE;
      end
      S_LVL_CLR: begin
        lvl_we    = 1'b1;
        lvl_waddr = NB'(clr);
        if (clr == (2*NB)'(MAX_NODES - 1)) state_next = S_BFS_INIT;
      end
      S_BFS_INIT: begin
        lvl_we     = 1'b1;
        q_we       = 1'b1;
        state_next = S_BFS_HEAD;
      end
      S_BFS_HEAD: begin
        q_raddr = NB'(head);
        if (head < tail) begin
          state_next = S_BFS_HEADW;
        end else if (reached) begin
          state_next = S_AUG_INIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BFS_HEADW: begin
        lvl_raddr  = q_rdata;
        state_next = S_BFS_LVLW;
      end
      S_BFS_LVLW: state_next = S_BFS_ISSUE;
      S_BFS_ISSUE: begin
        cap_raddr  = {u, v_idx};
        state_next = v_lt_n ? S_BFS_EVAL : S_BFS_HEAD;
      end
      S_BFS_EVAL: begin
        if (cap_rdata != '0 && !visited[v_idx] && tail < TW'(MAX_NODES)) begin
          lvl_we    = 1'b1;
          lvl_waddr = v_idx;
          lvl_wdata = LB'(lvl_inc);
          q_we      = 1'b1;
          q_waddr   = NB'(tail);
          q_wdata   = v_idx;
        end
        state_next = S_BFS_ISSUE;
      end
      S_AUG_INIT: begin
        st_we      = 1'b1;
        nt_we      = 1'b1;
        state_next = S_DFS_TOP;
      end
      S_DFS_TOP: begin
        nt_raddr  = u;
        lvl_raddr = u;
        state_next = (u == sink) ? S_NK_RD : S_DFS_TRYW;
      end
      S_DFS_TRYW: state_next = S_DFS_ISSUE;
      S_DFS_ISSUE: begin
        cap_raddr  = {u, v_idx};
        lvl_raddr  = v_idx;
        state_next = v_lt_n ? S_DFS_EVAL : S_DFS_POP;
      end
      S_DFS_EVAL: begin
        if (dfs_ok && depth_ok) begin
          nt_we      = 1'b1;
          nt_waddr   = u;
          nt_wdata   = v + (NB + 1)'(1);
          st_we      = 1'b1;
          st_waddr   = SAW'(depth);
          st_wdata   = v_idx;
          state_next = S_DFS_PUSH2;
        end else if (dfs_ok) begin
          state_next = S_DFS_POP;
        end else begin
          state_next = S_DFS_ISSUE;
        end
      end
      S_DFS_PUSH2: begin
        nt_we      = 1'b1;
        nt_waddr   = v_idx;
        state_next = S_DFS_TOP;
      end
      S_DFS_POP: begin
        st_raddr   = SAW'(depth - DW'(1));
        state_next = (depth == '0) ? S_DONE : S_DFS_POPW;
      end
      S_DFS_POPW: state_next = S_DFS_TOP;
      S_NK_RD: begin
        st_raddr   = SAW'(idx + DW'(1));
        state_next = (idx + DW'(1) < depth) ? S_NK_RDW : S_UP_RD;
      end
      S_NK_RDW: begin
        cap_raddr  = {a, st_rdata};
        state_next = S_NK_CMP;
      end
      S_NK_CMP: state_next = S_NK_RD;
      S_UP_RD: begin
        st_raddr   = SAW'(idx + DW'(1));
        state_next = (idx + DW'(1) < depth) ? S_UP_RDW : S_BFS_INIT;
      end
      S_UP_RDW: begin
        cap_raddr  = {a, st_rdata};
        state_next = S_UP_SUB;
      end
      S_UP_SUB: begin
        cap_we     = 1'b1;
        cap_waddr  = {a, b};
        cap_wdata  = CB'(NW'(cap_rdata) - neck);
        cap_raddr  = {b, a};
        state_next = S_UP_ADD;
      end
      S_UP_ADD: begin
        cap_we     = 1'b1;
        cap_waddr  = {b, a};
        cap_wdata  = CB'(NW'(cap_rdata) + neck);
        state_next = S_UP_RD;
      end
      S_DONE: begin
        if (!out_valid) state_next = S_CLEAR;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
      out_valid  <= 1'b0;
      clr        <= '0;
    end else begin
      if (cfg.valid && cfg.ready) node_count <= cfg.data;
      if (result.valid && result.ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR:   clr <= clr + (2*NB)'(1);
        S_IDLE: begin
          clr <= '0;
          if (in_acc) begin
            e_addr <= {NB'(edges.from_node), NB'(edges.to_node)};
            e_cap  <= edges.capacity;
          end
        end
        S_LVL_CLR: begin
          clr  <= clr + (2*NB)'(1);
          flow <= '0;
        end
        S_BFS_INIT: begin
          visited <= MAX_NODES'(1);
          head    <= '0;
          tail    <= TW'(1);
          reached <= 1'b0;
        end
        S_BFS_HEAD: if (head < tail) head <= head + TW'(1);
        S_BFS_HEADW: begin
          u <= q_rdata;
          if (q_rdata == sink) reached <= 1'b1;
        end
        S_BFS_LVLW: begin
          lvl_u <= lvl_rdata;
          v     <= '0;
        end
        S_BFS_EVAL: begin
          if (cap_rdata != '0 && !visited[v_idx] && tail < TW'(MAX_NODES)) begin
            visited[v_idx] <= 1'b1;
            tail           <= tail + TW'(1);
          end
          v <= v + (NB + 1)'(1);
        end
        S_AUG_INIT: begin
          dead  <= '0;
          depth <= DW'(1);
          u     <= '0;
        end
        S_DFS_TOP: begin
          neck <= NW'(PUSH_LIMIT);
          idx  <= '0;
          a    <= '0;
        end
        S_DFS_TRYW: begin
          v     <= nt_rdata;
          lvl_u <= lvl_rdata;
        end
        S_DFS_ISSUE: begin
          if (!v_lt_n) begin
            dead[u] <= 1'b1;
            depth   <= depth - DW'(1);
          end
        end
        S_DFS_EVAL: begin
          if (dfs_ok && depth_ok) begin
            depth <= depth + DW'(1);
          end else if (dfs_ok) begin
            dead[u] <= 1'b1;
            depth   <= depth - DW'(1);
          end else begin
            v <= v + (NB + 1)'(1);
          end
        end
        S_DFS_PUSH2: u <= v_idx;
        S_DFS_POPW:  u <= st_rdata;
        S_NK_RD: begin
          if (!(idx + DW'(1) < depth)) begin
            idx <= '0;
            a   <= '0;
          end
        end
        S_NK_RDW: b <= st_rdata;
        S_NK_CMP: begin
          if (NW'(cap_rdata) < neck) neck <= NW'(cap_rdata);
          a   <= b;
          idx <= idx + DW'(1);
        end
        S_UP_RD: begin
          if (!(idx + DW'(1) < depth)) flow <= flow + FLOW_W'(neck);
        end
        S_UP_RDW: b <= st_rdata;
        S_UP_ADD: begin
          a   <= b;
          idx <= idx + DW'(1);
        end
        S_DONE: begin
          clr <= '0;
          if (!out_valid) begin
            out_valid <= 1'b1;
            max_flow  <= flow;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mflg_ram.sv =====
// ----------------------------------------------------------------------------
// mflg_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mflg_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mflg_checker.sv =====
// ----------------------------------------------------------------------------
// mflg_checker
// Port-level checks on the max flow block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mflg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_opcode,
  input wire logic out_valid,
  input wire logic out_ready
);
  import mflg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_opcode == OP_RUN |=> !in_ready)
    else $error("ready after run beat");

  a_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("not idle-clearing after reset");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("input ready while result appears");

endmodule

bind max_flow_level_graph mflg_checker u_mflg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (edges.valid),
  .in_ready  (edges.ready),
  .in_opcode (edges.opcode),
  .out_valid (result.valid),
  .out_ready (result.ready)
);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for max_flow_level_graph. A directed table of edge and run beats
// comes first, then random graphs under several node counts and idle patterns.
// Each run is checked against an in-bench max flow predictor or a typed flow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mflg_pkg::*;

  localparam int LIMIT_CYCLES = 10000000;
  localparam int SETTLE       = 5000;
  localparam int NN           = 64;
  localparam longint unsigned CAP_SAT = (64'd1 << 24) - 1;

  logic clk;
  logic rst;

  mflg_in_if  edges_if ();
  mflg_out_if res_if ();
  mflg_cfg_if cfg_if ();

  max_flow_level_graph dut (
    .clk    (clk),
    .rst    (rst),
    .edges  (edges_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // predictor state
  longint unsigned resid [NN*NN];
  int unsigned     level [NN];
  bit              seen [NN];
  bit              dead [NN];
  int unsigned     bfs_q [NN];
  int unsigned     path [NN+1];
  longint unsigned flow_acc;
  logic [NCOUNT_W-1:0] nodes_cfg;

  logic [FLOW_W-1:0] flow_q [$];
  int errors;
  int runs_seen;
  int edges_sent;
  longint cycles;
  int idle_pct;
  int stall_pct;
  int hold_cycles;
  bit cur_typed;
  logic [FLOW_W-1:0] cur_flow;
  logic [FLOW_W-1:0] cur_flow_typed;

  typedef struct packed {
    bit                    is_cfg;
    logic [NCOUNT_W-1:0]   cdata;
    logic [OPCODE_W-1:0]   op;
    logic [NODE_W-1:0]     f;
    logic [NODE_W-1:0]     t;
    logic [CAPACITY_W-1:0] c;
    bit                    typed;
    logic [FLOW_W-1:0]     flow;
  } row_t;

  row_t plan [] = '{
    '{0, 0, OP_RUN,  0,  0, 24'h0,      1, 30'd0},
    '{0, 0, OP_EDGE, 0, 63, 24'hFFFFFF, 0, 30'd0},
    '{0, 0, OP_EDGE, 0, 63, 24'h1,      0, 30'd0},
    '{0, 0, OP_RUN, 63, 63, 24'hFFFFFF, 1, 30'hFFFFFF},
    '{0, 0, OP_EDGE, 0,  1, 24'd5,      0, 30'd0},
    '{0, 0, OP_EDGE, 1, 63, 24'd3,      0, 30'd0},
    '{0, 0, OP_EDGE, 0, 63, 24'd0,      0, 30'd0},
    '{0, 0, OP_RUN,  0,  0, 24'd0,      1, 30'd3},
    '{0, 0, OP_EDGE, 63, 0, 24'd7,      0, 30'd0},
    '{0, 0, OP_RUN,  0,  0, 24'd0,      1, 30'd0},
    '{0, 0, OP_EDGE, 0,  5, 24'd10,     0, 30'd0},
    '{0, 0, OP_EDGE, 5,  6, 24'd4,      0, 30'd0},
    '{0, 0, OP_EDGE, 6, 63, 24'd9,      0, 30'd0},
    '{0, 0, OP_EDGE, 0,  6, 24'd2,      0, 30'd0},
    '{0, 0, OP_EDGE, 6,  5, 24'd1,      0, 30'd0},
    '{0, 0, OP_RUN,  0,  0, 24'd0,      0, 30'd0},
    '{1, 7'd0, OP_EDGE, 0, 0, 24'd0,    0, 30'd0},
    '{0, 0, OP_EDGE, 0,  1, 24'd8,      0, 30'd0},
    '{0, 0, OP_EDGE, 0,  5, 24'd9,      0, 30'd0},
    '{0, 0, OP_EDGE, 5,  1, 24'd1,      0, 30'd0},
    '{0, 0, OP_RUN,  0,  0, 24'd0,      1, 30'd8},
    '{1, 7'd127, OP_EDGE, 0, 0, 24'd0,  0, 30'd0},
    '{0, 0, OP_EDGE, 0, 63, 24'd1,      0, 30'd0},
    '{0, 0, OP_EDGE, 63, 63, 24'hFFFFFF, 0, 30'd0},
    '{0, 0, OP_RUN,  0,  0, 24'd0,      1, 30'd1},
    '{1, 7'd3, OP_EDGE, 0, 0, 24'd0,    0, 30'd0},
    '{0, 0, OP_EDGE, 0,  1, 24'hFFFFFF, 0, 30'd0},
    '{0, 0, OP_EDGE, 1,  2, 24'hFFFFFF, 0, 30'd0},
    '{0, 0, OP_EDGE, 0,  2, 24'hFFFFFF, 0, 30'd0},
    '{0, 0, OP_EDGE, 2,  0, 24'd5,      0, 30'd0},
    '{0, 0, OP_RUN,  0,  0, 24'd0,      0, 30'd0}
  };

  function automatic int unsigned node_span();
    if (nodes_cfg < 2) return 2;
    if (nodes_cfg > NN) return NN;
    return 32'(nodes_cfg);
  endfunction

  function automatic bit levels_reach(int unsigned n);
    int unsigned head, tail, u;
    bit reached;
    head = 0;
    tail = 0;
    reached = 0;
    foreach (seen[i]) seen[i] = 0;
    seen[0] = 1;
    level[0] = 0;
    bfs_q[tail++] = 0;
    while (head < tail) begin
      u = bfs_q[head++];
      if (u == n - 1) reached = 1;
      for (int unsigned v = 0; v < n; v++) begin
        if (resid[u*NN+v] > 0 && !seen[v] && tail < NN) begin
          seen[v] = 1;
          level[v] = level[u] + 1;
          bfs_q[tail++] = v;
        end
      end
    end
    return reached;
  endfunction

  function automatic bit push_path(int unsigned n);
    int unsigned next_try [NN];
    int unsigned depth, u, v, a, b, sink;
    longint unsigned neck, c;
    depth = 1;
    sink = n - 1;
    foreach (dead[i]) dead[i] = 0;
    path[0] = 0;
    next_try[0] = 0;
    while (depth > 0) begin
      u = path[depth-1];
      if (u == sink) begin
        neck = PUSH_LIMIT;
        for (int unsigned i = 0; i + 1 < depth; i++) begin
          c = resid[path[i]*NN + path[i+1]];
          if (c < neck) neck = c;
        end
        for (int unsigned i = 0; i + 1 < depth; i++) begin
          a = path[i];
          b = path[i+1];
          resid[a*NN+b] -= neck;
          resid[b*NN+a] += neck;
        end
        flow_acc += neck;
        return 1;
      end
      for (v = next_try[u]; v < n; v++) begin
        if (resid[u*NN+v] > 0 && (level[v] == level[u] + 1 || v == sink) && !dead[v])
          break;
      end
      if (v < n && depth <= NN) begin
        next_try[u] = v + 1;
        next_try[v] = 0;
        path[depth++] = v;
      end else begin
        dead[u] = 1;
        depth--;
      end
    end
    return 0;
  endfunction

  function automatic logic [FLOW_W-1:0] solve_flow();
    int unsigned n;
    logic [FLOW_W-1:0] f;
    n = node_span();
    flow_acc = 0;
    foreach (level[i]) level[i] = 0;
    while (levels_reach(n)) begin
      if (!push_path(n)) break;
    end
    f = flow_acc[FLOW_W-1:0];
    foreach (resid[i]) resid[i] = 0;
    flow_acc = 0;
    return f;
  endfunction

  function automatic void add_edge(int unsigned f, int unsigned t, longint unsigned c);
    int unsigned n;
    longint unsigned sum;
    n = node_span();
    if (f < n && t < n) begin
      sum = resid[f*NN+t] + c;
      if (sum > CAP_SAT) sum = CAP_SAT;
      if (resid[f*NN+t] <= CAP_SAT) resid[f*NN+t] = sum;
    end
  endfunction

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  // accepted input beats drive the predictor
  always @(posedge clk) begin
    if (!rst && edges_if.valid && edges_if.ready) begin
      if (edges_if.opcode == OP_EDGE) begin
        add_edge(32'(edges_if.from_node), 32'(edges_if.to_node), 64'(edges_if.capacity));
      end else begin
        cur_flow = solve_flow();
        if (cur_typed) flow_q = {flow_q, cur_flow_typed};
        else flow_q = {flow_q, cur_flow};
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      runs_seen++;
      if (flow_q.size() == 0) begin
        report($sformatf("unexpected result max_flow=%0d", res_if.max_flow));
      end else if (res_if.max_flow !== flow_q[0]) begin
        report($sformatf("max_flow got %0d want %0d", res_if.max_flow, flow_q[0]));
        void'(flow_q.pop_front());
      end else begin
        void'(flow_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_if.ready = 0;
      hold_cycles--;
    end else begin
      res_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [NODE_W-1:0] f,
                           input logic [NODE_W-1:0] t, input logic [CAPACITY_W-1:0] c,
                           input bit typed, input logic [FLOW_W-1:0] fl);
    while ($urandom_range(99) < idle_pct) begin
      edges_if.valid = 0;
      @(negedge clk);
    end
    edges_if.valid = 1;
    edges_if.opcode = op;
    edges_if.from_node = f;
    edges_if.to_node = t;
    edges_if.capacity = c;
    cur_typed = typed;
    cur_flow_typed = fl;
    do @(posedge clk); while (!edges_if.ready);
    @(negedge clk);
    edges_if.valid = 0;
    cur_typed = 0;
    if (op == OP_EDGE) edges_sent++;
  endtask

  task automatic write_nodes(input logic [NCOUNT_W-1:0] v);
    wait (flow_q.size() == 0);
    @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_if.valid = 1;
    cfg_if.data = v;
    do @(posedge clk); while (!cfg_if.ready);
    nodes_cfg = v;
    @(negedge clk);
    cfg_if.valid = 0;
  endtask

  function automatic int unsigned pick_node(int unsigned n);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return 0;
    if (r < 40) return n - 1;
    return $urandom_range(n - 1, 0);
  endfunction

  function automatic logic [CAPACITY_W-1:0] pick_cap();
    case ($urandom_range(3))
      0: return CAPACITY_W'($urandom_range(20, 1));
      1: return CAPACITY_W'($urandom);
      2: return 24'hFFFFFF;
      default: return CAPACITY_W'($urandom_range(3, 0));
    endcase
  endfunction

  task automatic random_graph(inout int sent);
    int unsigned n, k, f, t;
    n = node_span();
    k = (n > 8) ? $urandom_range(8, 1) : $urandom_range(12, 1);
    repeat (k) begin
      if ($urandom_range(99) < 8) begin
        f = $urandom_range(63, 0);
        t = $urandom_range(63, 0);
      end else begin
        f = pick_node(n);
        t = pick_node(n);
      end
      send_beat(OP_EDGE, NODE_W'(f), NODE_W'(t), pick_cap(), 1'b0, '0);
      sent++;
    end
    send_beat(OP_RUN, NODE_W'($urandom), NODE_W'($urandom), CAPACITY_W'($urandom),
              1'b0, '0);
    sent++;
  endtask

  logic [NCOUNT_W-1:0] node_set [] = '{7'd0, 7'd1, 7'd2, 7'd4, 7'd6, 7'd8, 7'd5,
                                       7'd12, 7'd16, 7'd3, 7'd127, 7'd7, 7'd64, 7'd10};

  initial begin
    int sent;
    int seg;
    errors = 0;
    runs_seen = 0;
    edges_sent = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    cur_typed = 0;
    cur_flow_typed = 0;
    nodes_cfg = NODE_COUNT_RESET;
    flow_acc = 0;
    foreach (resid[i]) resid[i] = 0;
    foreach (level[i]) level[i] = 0;
    rst = 1;
    edges_if.valid = 0;
    edges_if.opcode = OP_EDGE;
    edges_if.from_node = 0;
    edges_if.to_node = 0;
    edges_if.capacity = 0;
    cfg_if.valid = 0;
    cfg_if.data = 0;
    res_if.ready = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_nodes(plan[i].cdata);
      else send_beat(plan[i].op, plan[i].f, plan[i].t, plan[i].c, plan[i].typed,
                     plan[i].flow);
    end

    sent = 0;
    seg = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      while (sent < (ph + 1) * 200) begin
        if (sent >= seg * 55) begin
          write_nodes((seg < node_set.size()) ? node_set[seg] :
                      NCOUNT_W'($urandom_range(12, 2)));
          seg++;
          if (ph == 3 && hold_cycles == 0 && seg % 2 == 0) hold_cycles = 3000;
        end
        random_graph(sent);
      end
    end

    wait (flow_q.size() == 0);
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d edge beats and %0d runs over %0d node count settings",
             edges_sent, runs_seen, seg + 3);
    if (errors == 0 && flow_q.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ===== max_flow_level_graph.f =====
rtl/mflg_pkg.sv
rtl/mflg_if.sv
rtl/mflg_ram.sv
rtl/max_flow_level_graph.sv
rtl/mflg_checker.sv
sim/tb.sv
